// ===== hw/rtl/icpc_pkg.sv =====
`default_nettype none

package icpc_pkg;

    localparam int PIX_W      = 8;
    localparam int CNT_W      = 22;
    localparam int OUT_CNT_W  = 23;
    localparam int THR_W      = 8;
    localparam int CFG_DIM_W  = 12;
    localparam int CFG_DATA_W = 23;
    // Wide enough for any configured dimension and for a maximum of 4096.
    localparam int DIM_W      = 13;
    localparam int MIN_DIM    = 3;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [THR_W-1:0]     THR_RESET    = 8'd28;
    localparam logic [OUT_CNT_W-1:0] MIN_RESET    = 23'd5000;
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 12'd256;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 12'd256;

    typedef enum logic [1:0] {
        REG_DIFF_THRESHOLD,
        REG_MIN_ACTIVE_COUNT,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== hw/rtl/icpc_line_buf.sv =====
`default_nettype none

module icpc_line_buf
    import icpc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [PIX_W-1:0]         i_wdata,
    output logic      [PIX_W-1:0]         o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // Read-first: the entry comes out as it was before this item overwrites it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/image_contrast_presence_check_top.sv =====
`default_nettype none

// Textured-pixel counter for grey frames.
// Input channel: one pixel per item in raster order, with frame_start marking
// the first pixel of a frame. An item is taken when i_valid is high and
// o_stall is low. Output channel: one item per frame, issued after the last
// pixel, carrying the textured pixel count and the has_content decision.
// Frame geometry, threshold and minimum count come from the write port and
// should only be changed between frames.
// Throughput is one pixel per cycle while o_stall is low. The result passes
// through the registered line-buffer read and then the compare-and-count
// stage that loads the output register.
// Reset clears position, count and the pipeline, and restores the default
// configuration; line-buffer contents are not cleared.
// While the receiver stalls a pending result, pixels keep flowing until a
// second end of frame reaches the count stage; only then is o_stall raised.
module image_contrast_presence_check_top
    import icpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIX_W-1:0]      i_pixel,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_has_content,
    output logic [OUT_CNT_W-1:0]       o_active_count,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] MIN_D   = DIM_W'(MIN_DIM);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [THR_W-1:0] t);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff > t;
    endfunction

    // Configuration registers.
    logic [THR_W-1:0]     r_thr;
    logic [OUT_CNT_W-1:0] r_min;
    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_min    <= MIN_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_DIFF_THRESHOLD:   r_thr    <= i_cfg_data[THR_W-1:0];
                REG_MIN_ACTIVE_COUNT: r_min    <= i_cfg_data[OUT_CNT_W-1:0];
                REG_IMAGE_WIDTH:      r_width  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT:     r_height <= i_cfg_data[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped geometry.
    logic [DIM_W-1:0] width_ext, height_ext, w_eff, h_eff;

    always_comb begin
        width_ext  = DIM_W'(r_width);
        height_ext = DIM_W'(r_height);
        if (width_ext < MIN_D) begin
            w_eff = MIN_D;
        end else if (width_ext > MAX_W_D) begin
            w_eff = MAX_W_D;
        end else begin
            w_eff = width_ext;
        end
        if (height_ext < MIN_D) begin
            h_eff = MIN_D;
        end else if (height_ext > MAX_H_D) begin
            h_eff = MAX_H_D;
        end else begin
            h_eff = height_ext;
        end
    end

    // Position stage: addresses the line buffer for the incoming pixel.
    logic [CW-1:0] r_col, n_col, col_cur;
    logic [RW-1:0] r_row, n_row, row_cur;
    logic          last_col, last_row, judge_cur;
    logic          in_accept;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic             r_s1_fs;
    logic             r_s1_judge;
    logic             r_s1_last;
    logic             s1_done;

    logic             r_out_valid;

    assign s1_done   = r_s1_valid && (!r_s1_last || !r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_done;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        col_cur   = i_frame_start ? '0 : r_col;
        row_cur   = i_frame_start ? '0 : r_row;
        last_col  = DIM_W'(col_cur) >= (w_eff - DIM_W'(1));
        last_row  = DIM_W'(row_cur) >= (h_eff - DIM_W'(1));
        judge_cur = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
        n_col     = r_col;
        n_row     = r_row;
        if (in_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row_cur + RW'(1);
            end else begin
                n_col = col_cur + CW'(1);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    logic [PIX_W-1:0] lb_rdata;

    icpc_line_buf #(
        .DEPTH(MAX_WIDTH)
    ) u_line_buf (
        .i_clk  (i_clk),
        .i_en   (in_accept),
        .i_addr (col_cur),
        .i_wdata(i_pixel),
        .o_rdata(lb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px    <= i_pixel;
            r_s1_fs    <= i_frame_start;
            r_s1_judge <= judge_cur;
            r_s1_last  <= last_col && last_row;
        end
    end

    // Compare-and-count stage. The centre is the pixel above-left of the
    // incoming one; its four neighbours are the incoming pixel and those above, left and left-left of it.
    logic [PIX_W-1:0] r_above_left, r_prev, r_prev2;
    logic [CNT_W-1:0] r_count, n_count, cnt_base, cnt_new;
    logic             hit;

    always_comb begin
        hit = r_s1_judge &&
              (exceeds(r_above_left, lb_rdata, r_thr) ||
               exceeds(r_above_left, r_prev, r_thr) ||
               exceeds(r_above_left, r_s1_px, r_thr) ||
               exceeds(r_above_left, r_prev2, r_thr));
        cnt_base = r_s1_fs ? '0 : r_count;
        cnt_new  = (hit && cnt_base != CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
        n_count  = r_count;
        if (s1_done) begin
            n_count = r_s1_last ? '0 : cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_above_left <= '0;
            r_prev       <= '0;
            r_prev2      <= '0;
        end else begin
            r_count <= n_count;
            if (s1_done) begin
                r_above_left <= lb_rdata;
                r_prev2      <= r_prev;
                r_prev       <= r_s1_px;
            end
        end
    end

    // Output register.
    logic [OUT_CNT_W-1:0] r_out_count;
    logic                 r_out_has;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_done && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && r_s1_last) begin
            r_out_count <= OUT_CNT_W'(cnt_new);
            r_out_has   <= OUT_CNT_W'(cnt_new) >= r_min;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_active_count = r_out_count;
    assign o_has_content  = r_out_has;

    // The count stage never loses an item to a new one.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && r_s1_valid && !s1_done))
        else $error("pixel accepted while count stage is blocked");

    // A new result only comes from a frame's last pixel.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_s1_valid && r_s1_last))
        else $error("result issued without an end of frame");

    // The count restarts when the frame result is issued.
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_count == '0))
        else $error("count not cleared at end of frame");

    // The 22-bit count never reaches the top bit of the reported field.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_out_count[OUT_CNT_W-1])
        else $error("reported count exceeds counter range");

endmodule

`default_nettype wire
